// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, codes and defaults used by the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Field widths of the configuration register and the stream payloads
  localparam int NR_W   = 13;
  localparam int IDX_W  = 12;
  localparam int CNT_W  = 12;
  localparam int STAT_W = 2;
  localparam int OP_W   = 1;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 2;

  // Defaults of the top-level parameters and the register reset value
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 64;
  localparam logic [NR_W-1:0] NR_BLOCKS_RESET = NR_W'(4096);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_ALLOC = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd3;

endpackage

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator of backing blocks over a bitmap held in one RAM.
// ----------------------------------------------------------------------------
// An allocate transaction scans the bitmap one RAM word per cycle from block 1
// upwards and takes the lowest free block below the limit min(nr_blocks,
// MaxBlocks). A free transaction splits the index into word and bit by a
// multiplication with a scaled reciprocal of the word width, then reads that
// word and writes it back with the bit cleared if it was set. Block 0 is never
// handed out. After reset the block clears the bitmap RAM word by word and
// accepts no request until that pass is done; configuration writes are taken
// throughout. A finished result sits in an output register, so the next
// request can be taken while it waits.

module bitmap_block_allocator #(
  parameter int MaxBlocks = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WordBits  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: nr_blocks
  input  logic                           cfg_we_i,
  input  logic [bba_pkg::NR_W-1:0]       cfg_wdata_i,
  // Requests
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bba_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [11:0] block_index
  input  logic [bba_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // [0] opcode
  // Results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bba_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [11:0] allocated_index,
                                                        // [23:12] blocks_in_use
  output logic [bba_pkg::M_TUSER_W-1:0]  m_axis_tuser   // [1:0] status
);

  import bba_pkg::*;

  localparam int MapWords = (MaxBlocks + WordBits - 1) / WordBits;
  localparam int AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int BW       = $clog2(WordBits);
  localparam int BASE_W   = NR_W + 1;
  localparam int EXT_W    = (AW > IDX_W) ? AW : IDX_W;
  localparam int DIV_SH   = IDX_W + BW;
  localparam int RECIP_W  = DIV_SH + 1;
  localparam int PROD_W   = IDX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RecipMul =
    RECIP_W'(((1 << DIV_SH) + WordBits - 1) / WordBits);
  localparam logic [NR_W-1:0] LimCap =
    (MaxBlocks >= 2 ** NR_W) ? {NR_W{1'b1}} : NR_W'(MaxBlocks);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_MOD   = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [NR_W-1:0]     nr_q, nr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                out_valid_q, out_valid_d;

  logic [AW-1:0]       word_q, word_d;
  logic [BASE_W-1:0]   base_q, base_d;
  logic [IDX_W-1:0]    dq_q, dq_d;
  logic [BW-1:0]       rem_q, rem_d;
  logic [STAT_W-1:0]   res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_index_q, res_index_d;
  logic [STAT_W-1:0]   out_status_q, out_status_d;
  logic [IDX_W-1:0]    out_index_q, out_index_d;
  logic [CNT_W-1:0]    out_count_q, out_count_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;

  logic [NR_W-1:0]     lim;
  logic [BASE_W-1:0]   lim_ext, span, base_next, given;
  logic [WordBits-1:0] mask, free_vec;
  logic                hit;
  logic [BW-1:0]       pos;
  logic [PROD_W-1:0]   quo_prod;
  logic [EXT_W-1:0]    quo_ext;
  logic [IDX_W-1:0]    word_base;
  logic [IDX_W-1:0]    rem_full;
  logic [IDX_W-1:0]    req_index;
  logic [OP_W-1:0]     req_op;
  logic                in_fire;
  logic [CNT_W-1:0]    cnt_inc, cnt_dec;

  bba_ram #(
    .Width (WordBits),
    .Depth (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_index = s_axis_tdata[IDX_W-1:0];
  assign req_op    = s_axis_tuser[OP_W-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign lim     = (nr_q > LimCap) ? LimCap : nr_q;
  assign lim_ext = BASE_W'(lim);
  assign span    = lim_ext - base_q;
  assign base_next = base_q + BASE_W'(WordBits);

  // Bits of the word under scan that lie in 1 .. limit-1 and are still free.
  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      mask[b] = (BASE_W'(b) < span) && !((b == 0) && (base_q == '0));
    end
    free_vec = ~ram_rdata & mask;
    hit      = |free_vec;
    pos      = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        pos = BW'(b);
      end
    end
  end

  assign given = base_q + BASE_W'(pos);

  // The word index is the index times a rounded-up reciprocal of the word
  // width, scaled far enough to be exact for every 12-bit index. The bit
  // position is what is left after removing that many whole words.
  assign quo_prod  = PROD_W'(dq_q) * PROD_W'(RecipMul);
  assign quo_ext   = EXT_W'(quo_prod[DIV_SH +: IDX_W]);
  assign word_base = IDX_W'(word_q) * IDX_W'(WordBits);
  assign rem_full  = dq_q - word_base;

  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
  assign cnt_dec = (cnt_q == '0) ? cnt_q : cnt_q - CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    nr_d         = cfg_we_i ? cfg_wdata_i : nr_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    word_d       = word_q;
    base_d       = base_q;
    dq_d         = dq_q;
    rem_d        = rem_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = word_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == AW'(MapWords - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_index_d = '0;
          if (req_op == OP_ALLOC) begin
            if (lim < NR_W'(2)) begin
              res_status_d = STATUS_FULL;
              state_d      = ST_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              word_d    = '0;
              base_d    = '0;
              state_d   = ST_SCAN;
            end
          end else if (req_index == '0 || NR_W'(req_index) >= lim) begin
            res_status_d = STATUS_RANGE;
            state_d      = ST_RESP;
          end else begin
            dq_d    = req_index;
            state_d = ST_DIV;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          ram_we       = 1'b1;
          ram_waddr    = word_q;
          ram_wdata    = ram_rdata | (WordBits'(1) << pos);
          cnt_d        = cnt_inc;
          res_status_d = STATUS_OK;
          res_index_d  = given[IDX_W-1:0];
          state_d      = ST_RESP;
        end else if (base_next >= lim_ext) begin
          res_status_d = STATUS_FULL;
          state_d      = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = word_q + AW'(1);
          word_d    = word_q + AW'(1);
          base_d    = base_next;
        end
      end
      ST_DIV: begin
        word_d  = quo_ext[AW-1:0];
        state_d = ST_READ;
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = word_q;
        rem_d     = rem_full[BW-1:0];
        state_d   = ST_MOD;
      end
      ST_MOD: begin
        // The count drops even when the bit was already clear.
        cnt_d = cnt_dec;
        if (ram_rdata[rem_q]) begin
          ram_we       = 1'b1;
          ram_waddr    = word_q;
          ram_wdata    = ram_rdata & ~(WordBits'(1) << rem_q);
          res_status_d = STATUS_OK;
        end else begin
          res_status_d = STATUS_NOT_ALLOC;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
          out_count_d  = cnt_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      nr_q        <= NR_BLOCKS_RESET;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nr_q        <= nr_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    base_q       <= base_d;
    dq_q         <= dq_d;
    rem_q        <= rem_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_index_q};
  assign m_axis_tuser  = out_status_q;

endmodule
